@@ design/text_console_writer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for clocked implication checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console writer: same-cycle check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");

`endif

@@ design/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// Text console writer package
// Shared constants, request codes and control structs.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int SCREEN_COLS_DEF = 80;
   localparam int SCREEN_ROWS_DEF = 25;

   localparam int CELL_W = 16;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_SET   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0] RESET_ATTR = 8'h07;

   typedef struct packed {
      logic       update;
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [6:0] target_col;
      logic [4:0] target_row;
   } tcw_cmd_type;

   typedef struct packed {
      logic scroll;
      logic write_cell;
   } tcw_move_type;

endpackage

@@ design/text_console_writer_unit.sv @@
// Put w/o scroll, set cursor: result next cycle; one word per cycle unless rsp stalls.
// Read cell: result via the registered cell store read, then the response register.
// Clear: fills all CELLS cells, one cell fill per cycle, CELLS = SCREEN_COLS*SCREEN_ROWS.
// Scroll: one cell copied or filled per cycle through the store port, last row blanked.
// Reset: cursor to 0, attribute to 7; a fill pass writes blank cells everywhere, no
// request word is taken until it ends (CSR writes are accepted throughout).
`include "text_console_writer_unit_macros.svh"
// ---------------------------------------------------------------------------
// Text console writer
// Character cell screen with cursor, scroll, clear and cell read requests.
// ---------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_code, [14:8] target_col, [19:15] target_row, [30:20] cell_index, [31] zero
   input  logic [31:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_offset, [23] did_scroll,
   // [31:24] read_char, [39:32] read_attr
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(SCREEN_COLS);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELL_COUNT - SCREEN_COLS);
   localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_COLS);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_COPY   = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]        attr_ff;
   logic              res_scroll_ff, res_scroll_in;
   logic              res_read_ff, res_read_in;

   logic              rsp_valid_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [ADDR_W-1:0] rsp_off_ff;
   logic              rsp_scroll_ff;
   logic [7:0]        rsp_char_ff;
   logic [7:0]        rsp_attr_ff;

   logic [7:0]  in_char;
   logic [6:0]  in_col;
   logic [4:0]  in_row;
   logic [10:0] in_idx;

   tcw_cmd_type  cmd;
   tcw_move_type move;
   logic [COL_W-1:0] cur_col, nxt_col, out_col;
   logic [ROW_W-1:0] cur_row, nxt_row, out_row;
   logic [ADDR_W-1:0] cur_pos, out_pos;

   logic              slot_free;
   logic              req_accept;
   logic              simple_req;
   logic              rsp_load;
   logic              idx_ok;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   assign in_char = req_tdata[7:0];
   assign in_col  = req_tdata[14:8];
   assign in_row  = req_tdata[19:15];
   assign in_idx  = req_tdata[30:20];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign req_accept = req_tvalid && req_tready;
   assign idx_ok     = 32'(in_idx) < CELL_COUNT;

   assign cmd.update     = req_accept;
   assign cmd.req_type   = req_tuser;
   assign cmd.char_code  = in_char;
   assign cmd.target_col = in_col;
   assign cmd.target_row = in_row;

   tcw_cursor #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_cursor (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .col_now (cur_col),
      .row_now (cur_row),
      .col_next(nxt_col),
      .row_next(nxt_row),
      .move    (move)
   );

   assign simple_req = ((req_tuser == REQ_PUT) && !move.scroll) || (req_tuser == REQ_SET);

   assign cur_pos = ADDR_W'(32'(cur_row) * SCREEN_COLS + 32'(cur_col));
   // fast path reports the new cursor; delayed results read the committed one
   assign out_col = (state_ff == S_IDLE) ? nxt_col : cur_col;
   assign out_row = (state_ff == S_IDLE) ? nxt_row : cur_row;
   assign out_pos = ADDR_W'(32'(out_row) * SCREEN_COLS + 32'(out_col));

   assign rsp_load = (req_accept && simple_req) || ((state_ff == S_RESULT) && slot_free);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_scroll_in = res_scroll_ff;
      res_read_in   = res_read_ff;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff;
      ram_wdata     = {attr_ff, CH_SPACE};
      ram_re        = 1'b0;
      ram_raddr     = ADDR_W'(in_idx);
      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = {RESET_ATTR, CH_SPACE};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               res_scroll_in = 1'b0;
               res_read_in   = 1'b0;
               cnt_in        = '0;
               unique case (req_tuser)
                  REQ_PUT: begin
                     ram_we    = move.write_cell;
                     ram_waddr = cur_pos;
                     ram_wdata = {attr_ff, in_char};
                     if (move.scroll) begin
                        res_scroll_in = 1'b1;
                        state_in      = S_COPY;
                     end
                  end
                  REQ_SET: begin
                     state_in = S_IDLE;
                  end
                  REQ_CLEAR: begin
                     state_in = S_FILL;
                  end
                  REQ_READ: begin
                     ram_re      = idx_ok;
                     res_read_in = idx_ok;
                     state_in    = S_RESULT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_COPY: begin
            // read one row ahead, write back the previous read
            ram_re       = 1'b1;
            ram_raddr    = cnt_ff + ROW_STEP;
            pend_in      = 1'b1;
            pend_addr_in = cnt_ff;
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (cnt_ff == COPY_END) begin
               cnt_in   = LAST_BASE;
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FILL: begin
            ram_we = 1'b1;
            if (pend_ff) begin
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_CELL) begin
                  state_in = S_RESULT;
               end
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   tcw_cell_ram #(
      .DEPTH (CELL_COUNT),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         attr_ff       <= RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
         res_scroll_ff <= 1'b0;
         res_read_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         res_scroll_ff <= res_scroll_in;
         res_read_ff   <= res_read_in;
         if (csr_we) begin
            attr_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (rsp_load) begin
         rsp_col_ff    <= out_col;
         rsp_row_ff    <= out_row;
         rsp_off_ff    <= out_pos;
         rsp_scroll_ff <= (state_ff == S_RESULT) && res_scroll_ff;
         rsp_char_ff   <= ((state_ff == S_RESULT) && res_read_ff) ? ram_rdata[7:0] : 8'h00;
         rsp_attr_ff   <= ((state_ff == S_RESULT) && res_read_ff) ? ram_rdata[15:8] : 8'h00;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_attr_ff, rsp_char_ff, rsp_scroll_ff, 11'(rsp_off_ff),
                        5'(rsp_row_ff), 7'(rsp_col_ff)};

   `TCW_ASSERT_IMPL(a_copy_no_overlap, (state_ff == S_COPY) && pend_ff, ram_raddr != pend_addr_ff)
   `TCW_ASSERT_IMPL(a_cursor_range, state_ff != S_INIT, (32'(cur_col) < SCREEN_COLS) && (32'(cur_row) < SCREEN_ROWS))
   `TCW_ASSERT_IMPL(a_scroll_home, rsp_valid_ff && rsp_scroll_ff, (rsp_col_ff == '0) && (32'(rsp_row_ff) == SCREEN_ROWS - 1))
   `TCW_ASSERT_NEXT(a_fast_result, req_accept && simple_req, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

@@ design/tcw_cell_ram.sv @@
// ---------------------------------------------------------------------------
// Screen cell store
// One write port and one registered read port.
// ---------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter int DEPTH  = tcw_pkg::SCREEN_COLS_DEF * tcw_pkg::SCREEN_ROWS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tcw_cursor.sv @@
// ---------------------------------------------------------------------------
// Cursor unit
// Holds the cursor and works out its next position for each request.
// ---------------------------------------------------------------------------
module tcw_cursor #(
   parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
   parameter int COL_W       = $clog2(SCREEN_COLS),
   parameter int ROW_W       = $clog2(SCREEN_ROWS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_pkg::tcw_cmd_type cmd,
   output logic [COL_W-1:0]     col_now,
   output logic [ROW_W-1:0]     row_now,
   output logic [COL_W-1:0]     col_next,
   output logic [ROW_W-1:0]     row_next,
   output tcw_pkg::tcw_move_type move
);
   import tcw_pkg::*;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             scroll;
   logic             write_cell;
   logic             do_advance;
   logic             do_feed;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      scroll     = 1'b0;
      write_cell = 1'b0;
      do_advance = 1'b0;
      do_feed    = 1'b0;
      unique case (cmd.req_type)
         REQ_PUT: begin
            priority if (cmd.char_code == CH_BS) begin
               if (col_ff != '0) begin
                  col_in = col_ff - 1'b1;
               end else if (row_ff != '0) begin
                  row_in = row_ff - 1'b1;
               end
            end else if (cmd.char_code == CH_TAB) begin
               do_advance = 1'b1;
            end else if (cmd.char_code == CH_CR) begin
               col_in = '0;
            end else if (cmd.char_code == CH_LF) begin
               do_feed = 1'b1;
            end else if (cmd.char_code >= CH_SPACE) begin
               write_cell = 1'b1;
               do_advance = 1'b1;
            end else begin
               col_in = col_ff;
            end
            // advance wraps into a line feed at the last column
            if (do_advance) begin
               if (col_ff < LAST_COL) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  col_in  = '0;
                  do_feed = 1'b1;
               end
            end
            if (do_feed) begin
               if (row_ff < LAST_ROW) begin
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = '0;
                  scroll = 1'b1;
               end
            end
         end
         REQ_SET: begin
            col_in = (32'(cmd.target_col) > SCREEN_COLS - 1) ? LAST_COL
                                                           : COL_W'(cmd.target_col);
            row_in = (32'(cmd.target_row) > SCREEN_ROWS - 1) ? LAST_ROW
                                                           : ROW_W'(cmd.target_row);
         end
         REQ_CLEAR, REQ_READ: begin
            col_in = col_ff;
         end
         default: begin
            col_in = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.update) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col_now         = col_ff;
   assign row_now         = row_ff;
   assign col_next        = col_in;
   assign row_next        = row_in;
   assign move.scroll     = scroll;
   assign move.write_cell = write_cell;

endmodule
